>>> rtl/afie_pkg.sv
// Shared constants, types and the quarter-wave sine table of the angular Fourier engine.
package afie_pkg;

    localparam int PAN_HARMONICS  = 8;
    localparam int TILT_HARMONICS = 8;
    localparam int PAIR_COUNT     = PAN_HARMONICS * TILT_HARMONICS;
    localparam int HARM_W         = 3;
    localparam int PAIR_W         = 6;
    localparam int ANGLE_W        = 9;
    localparam int TRIG_W         = 16;
    localparam int SUM_W          = 32;
    localparam int ROW_W          = 4 * SUM_W;
    localparam int QUARTER_ENTRIES = 91;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [QUARTER_ENTRIES-1:0][TRIG_W-1:0] sin_tab_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_val;
        logic signed [TRIG_W-1:0] cos_val;
    } trig_pair_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_EM_RD,
        ST_EM_SQ,
        ST_EM_SUM,
        ST_EM_OUT,
        ST_EM_WAIT
    } afie_state_t;

    // Q1.15 sine of 0..90 degrees from a Q30 Taylor series, rounded and clipped.
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t           t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic [63:0]        q;
        for (int k = 0; k < QUARTER_ENTRIES; k++)
        begin
            x    = (64'(k) * PI_Q30) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            s    = $signed(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    s = s - $signed(term);
                else
                    s = s + $signed(term);
            end
            if (s < 0)
                s = 0;
            q = ($unsigned(s) + 64'd16384) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            t[k] = q[TRIG_W-1:0];
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

>>> rtl/afie_trig.sv
// Sine and cosine lookup of a whole-degree angle through quadrant folding.
module afie_trig (
    input  logic [afie_pkg::ANGLE_W-1:0] angle,
    output afie_pkg::trig_pair_t         trig
);
    import afie_pkg::*;

    logic [ANGLE_W-1:0] cos_angle;

    function automatic logic signed [TRIG_W-1:0] fold_sin(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W-1:0] k;
        logic               neg;
        logic [TRIG_W-1:0]  mag;
        if (d <= ANGLE_W'(90))
        begin
            k   = d;
            neg = 1'b0;
        end
        else if (d <= ANGLE_W'(180))
        begin
            k   = ANGLE_W'(180) - d;
            neg = 1'b0;
        end
        else if (d <= ANGLE_W'(270))
        begin
            k   = d - ANGLE_W'(180);
            neg = 1'b1;
        end
        else
        begin
            k   = ANGLE_W'(360) - d;
            neg = 1'b1;
        end
        mag = SIN_TAB[k[6:0]];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    always_comb
    begin
        cos_angle = angle + ANGLE_W'(90);
        if (cos_angle >= ANGLE_W'(360))
            cos_angle = cos_angle - ANGLE_W'(360);
        trig.sin_val = fold_sin(angle);
        trig.cos_val = fold_sin(cos_angle);
    end

endmodule

>>> rtl/angular_fourier_invariant_engine.sv
// Top level: coefficient accumulation over all harmonic pairs and invariant emission.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid/in_ready, pan_angle, tilt_angle,        | in
//          | intensity, last_point                            |
//  out     | out_valid/out_ready, harmonic_index, invariant,  | out
//          | last_result                                      |
//  cfg     | cfg_valid/cfg_ready, cfg_data (rho offset)       | in
//
// A new point is accepted only in idle, after its 64 pair slots have passed through the
// four-way multiply-accumulate pipeline (one read and one write port) and it has drained.
// A last point adds 64 results, each through read, square, sum, output and out_ready wait.
// Reset clears control and the per-row valid bits; a row that is not valid reads as zero.
// The sum memory is 64 rows of four 32-bit sums; no clearing pass is needed.
module angular_fourier_invariant_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [afie_pkg::ANGLE_W-1:0]   pan_angle,
    input  logic [afie_pkg::ANGLE_W-1:0]   tilt_angle,
    input  logic [15:0]                    intensity,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [afie_pkg::PAIR_W-1:0]    harmonic_index,
    output logic [63:0]                    invariant,
    output logic                           last_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [15:0]                    cfg_data
);
    import afie_pkg::*;

    afie_state_t state_reg, state_next;

    logic [15:0]          rho_offset_reg;
    logic [ANGLE_W-1:0]   pan_reg, tilt_reg;
    logic [16:0]          rho_reg;
    logic                 last_reg;

    logic [HARM_W-1:0]    h2_reg;
    logic [ANGLE_W-1:0]   pan_h_reg, tilt_h_reg;
    logic [ANGLE_W:0]     pan_sum, tilt_sum;
    logic [PAIR_W-1:0]    k_reg;

    trig_pair_t           pan_trig, tilt_trig;

    // pipeline
    logic                 v0_reg, v1_reg, v2_reg;
    logic [PAIR_W-1:0]    idx0_reg, idx1_reg, idx2_reg;
    logic signed [TRIG_W-1:0] cp0_reg, sp0_reg, ct0_reg, st0_reg, ct1_reg, st1_reg;
    logic signed [33:0]   rpc_reg, rps_reg;
    logic signed [49:0]   pa_reg, pb_reg, pc_reg, pd_reg;

    // memory
    logic [ROW_W-1:0]     mem [0:PAIR_COUNT-1];
    logic [PAIR_COUNT-1:0] row_valid_reg;
    logic [ROW_W-1:0]     rdata_reg;
    logic                 rvalid_reg;
    logic [PAIR_W-1:0]    rd_addr;
    logic [ROW_W-1:0]     row_data;
    logic [ROW_W-1:0]     wdata;

    // emission
    logic [63:0]          sqa_reg, sqb_reg, sqc_reg, sqd_reg;
    logic [63:0]          sac_reg, sbd_reg;
    logic [64:0]          inv_sum;
    logic                 out_valid_reg, last_result_reg;
    logic [PAIR_W-1:0]    harmonic_index_reg;
    logic [63:0]          invariant_reg;

    // control
    logic                 accept_in, issue, acc_done, pipe_empty, em_last, take_out;

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] acc,
                                                       input logic signed [49:0]      prod);
        logic signed [21:0] term;
        logic signed [33:0] s;
        term = 22'(prod >>> 28);
        s    = 34'(acc) + 34'(term);
        if (s > 34'sh07FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (s < -34'sh080000000)
            return 32'sh80000000;
        return s[SUM_W-1:0];
    endfunction

    afie_trig u_pan_trig (
        .angle (pan_h_reg),
        .trig  (pan_trig)
    );

    afie_trig u_tilt_trig (
        .angle (tilt_h_reg),
        .trig  (tilt_trig)
    );

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == ST_IDLE);
    assign accept_in      = in_valid && in_ready;
    assign pipe_empty     = !v0_reg && !v1_reg && !v2_reg;
    assign acc_done       = (k_reg == PAIR_W'(PAIR_COUNT - 1));
    assign em_last        = (k_reg == PAIR_W'(PAIR_COUNT - 1));
    assign take_out       = out_valid_reg && out_ready;
    assign out_valid      = out_valid_reg;
    assign harmonic_index = harmonic_index_reg;
    assign invariant      = invariant_reg;
    assign last_result    = last_result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept_in) state_next = ST_ACC;
            ST_ACC:     if (acc_done) state_next = ST_DRAIN;
            ST_DRAIN:   if (pipe_empty) state_next = last_reg ? ST_EM_RD : ST_IDLE;
            ST_EM_RD:   state_next = ST_EM_SQ;
            ST_EM_SQ:   state_next = ST_EM_SUM;
            ST_EM_SUM:  state_next = ST_EM_OUT;
            ST_EM_OUT:  state_next = ST_EM_WAIT;
            ST_EM_WAIT: if (take_out) state_next = em_last ? ST_IDLE : ST_EM_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        issue   = 1'b0;
        rd_addr = idx1_reg;
        case (state_reg)
            ST_ACC:   issue = 1'b1;
            ST_EM_RD: rd_addr = k_reg;
            default:  issue = 1'b0;
        endcase
    end

    always_comb
    begin
        pan_sum  = {1'b0, pan_h_reg} + {1'b0, pan_reg};
        tilt_sum = {1'b0, tilt_h_reg} + {1'b0, tilt_reg};
        if (pan_sum >= (ANGLE_W + 1)'(360))
            pan_sum = pan_sum - (ANGLE_W + 1)'(360);
        if (tilt_sum >= (ANGLE_W + 1)'(360))
            tilt_sum = tilt_sum - (ANGLE_W + 1)'(360);
        row_data = rvalid_reg ? rdata_reg : '0;
        wdata = {sat_add(row_data[127:96], pd_reg), sat_add(row_data[95:64], pc_reg),
                 sat_add(row_data[63:32], pb_reg), sat_add(row_data[31:0], pa_reg)};
        inv_sum = {1'b0, sac_reg} + ((k_reg >= PAIR_W'(TILT_HARMONICS)) ? {1'b0, sbd_reg} : 65'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rho_offset_reg  <= '0;
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            row_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
            k_reg           <= '0;
            h2_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                rho_offset_reg <= cfg_data;
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            if (accept_in)
            begin
                k_reg  <= '0;
                h2_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + PAIR_W'(1);
                if (h2_reg == HARM_W'(TILT_HARMONICS - 1))
                    h2_reg <= '0;
                else
                    h2_reg <= h2_reg + HARM_W'(1);
            end
            else if (state_reg == ST_DRAIN && pipe_empty)
                k_reg <= '0;
            else if (state_reg == ST_EM_WAIT && take_out)
                k_reg <= k_reg + PAIR_W'(1);
            if (v2_reg)
                row_valid_reg[idx2_reg] <= 1'b1;
            else if (state_reg == ST_EM_RD)
                row_valid_reg[k_reg] <= 1'b0;
            if (state_reg == ST_EM_OUT)
                out_valid_reg <= 1'b1;
            else if (take_out)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and datapath
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            pan_reg    <= (pan_angle >= ANGLE_W'(360)) ? pan_angle - ANGLE_W'(360) : pan_angle;
            tilt_reg   <= (tilt_angle >= ANGLE_W'(360)) ? tilt_angle - ANGLE_W'(360) : tilt_angle;
            rho_reg    <= 17'(intensity) + 17'(rho_offset_reg);
            last_reg   <= last_point;
            pan_h_reg  <= '0;
            tilt_h_reg <= '0;
        end
        else if (issue)
        begin
            if (h2_reg == HARM_W'(TILT_HARMONICS - 1))
            begin
                tilt_h_reg <= '0;
                pan_h_reg  <= pan_sum[ANGLE_W-1:0];
            end
            else
                tilt_h_reg <= tilt_sum[ANGLE_W-1:0];
        end
        // stage 0: table lookup
        idx0_reg <= k_reg;
        cp0_reg  <= pan_trig.cos_val;
        sp0_reg  <= pan_trig.sin_val;
        ct0_reg  <= tilt_trig.cos_val;
        st0_reg  <= tilt_trig.sin_val;
        // stage 1: rho times pan trig
        idx1_reg <= idx0_reg;
        rpc_reg  <= $signed({1'b0, rho_reg}) * cp0_reg;
        rps_reg  <= $signed({1'b0, rho_reg}) * sp0_reg;
        ct1_reg  <= ct0_reg;
        st1_reg  <= st0_reg;
        // stage 2: times tilt trig, row read in flight
        idx2_reg <= idx1_reg;
        pa_reg   <= rpc_reg * ct1_reg;
        pb_reg   <= rps_reg * ct1_reg;
        pc_reg   <= rpc_reg * st1_reg;
        pd_reg   <= rps_reg * st1_reg;
        // emission squares and partial sums
        sqa_reg  <= 64'($signed(row_data[31:0]) * $signed(row_data[31:0]));
        sqb_reg  <= 64'($signed(row_data[63:32]) * $signed(row_data[63:32]));
        sqc_reg  <= 64'($signed(row_data[95:64]) * $signed(row_data[95:64]));
        sqd_reg  <= 64'($signed(row_data[127:96]) * $signed(row_data[127:96]));
        sac_reg  <= sqa_reg + sqc_reg;
        sbd_reg  <= sqb_reg + sqd_reg;
        if (state_reg == ST_EM_OUT)
        begin
            harmonic_index_reg <= k_reg;
            invariant_reg      <= inv_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : inv_sum[63:0];
            last_result_reg    <= em_last;
        end
    end

    // sum memory: one read, one write, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg  <= mem[rd_addr];
        rvalid_reg <= row_valid_reg[rd_addr];
        if (v2_reg)
            mem[idx2_reg] <= wdata;
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pipe_empty)
        else $error("pipeline busy while accepting");
    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EM_WAIT))
        else $error("result shown outside emission wait");
    a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_RD || state_reg == ST_EM_SQ || state_reg == ST_EM_SUM
         || state_reg == ST_EM_OUT || state_reg == ST_EM_WAIT) |-> !v2_reg)
        else $error("sum write during emission");
    a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_RD) |=> !row_valid_reg[$past(k_reg)])
        else $error("row not cleared after emission read");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the angular Fourier invariant engine.
`timescale 1ns / 1ps

module tb;
    import afie_pkg::*;

    typedef struct {
        logic [PAIR_W-1:0] harm;
        logic [63:0]       inv;
        logic              last;
    } invariant_exp_t;

    typedef struct {
        logic [ANGLE_W-1:0] pan;
        logic [ANGLE_W-1:0] tilt;
        logic [15:0]        inten;
        logic               last;
        logic               all_zero;
    } point_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [ANGLE_W-1:0]   pan_angle;
    logic [ANGLE_W-1:0]   tilt_angle;
    logic [15:0]          intensity;
    logic                 last_point;
    logic                 out_valid;
    logic                 out_ready;
    logic [PAIR_W-1:0]    harmonic_index;
    logic [63:0]          invariant;
    logic                 last_result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [15:0]          cfg_data;

    invariant_exp_t invariant_q[$];
    int             sin_quarter[0:90];
    int             coef_acc[PAIR_COUNT][4];
    int             offset_shadow;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             hold_req;
    int             hold_left;
    int             fail_count;
    int             points_sent;
    int             results_seen;
    int             sets_sent;

    angular_fourier_invariant_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pan_angle      (pan_angle),
        .tilt_angle     (tilt_angle),
        .intensity      (intensity),
        .last_point     (last_point),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .harmonic_index (harmonic_index),
        .invariant      (invariant),
        .last_result    (last_result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("FAIL angular_fourier_invariant_engine");
        $finish;
    end

    // Q1.15 sine of 0..90 degrees, Taylor series in Q30
    function automatic int quarter_sine(int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        r;
        x  = (64'(k) * 64'd3373259426) / 64'd180;
        x2 = (x * x) >> 30;
        t  = x;
        s  = $signed(x);
        for (int n = 1; n <= 8; n++)
        begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            s = (n % 2 == 1) ? s - $signed(t) : s + $signed(t);
        end
        if (s < 0)
            s = 0;
        r = ($unsigned(s) + 64'd16384) >> 15;
        return (r > 64'd32767) ? 32767 : int'(r);
    endfunction

    function automatic int deg_sin(int d);
        d = d % 360;
        if (d <= 90)
            return sin_quarter[d];
        if (d <= 180)
            return sin_quarter[180 - d];
        if (d <= 270)
            return -sin_quarter[d - 180];
        return -sin_quarter[360 - d];
    endfunction

    function automatic int deg_cos(int d);
        return deg_sin((d % 360) + 90);
    endfunction

    function automatic void add_term(int p, int f, longint rho, int t1, int t2);
        longint s;
        s = longint'(coef_acc[p][f]) + ((rho * t1 * t2) >>> 28);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        coef_acc[p][f] = int'(s);
    endfunction

    function automatic logic [63:0] sq_add(logic [63:0] acc, int v);
        logic [64:0] r;
        longint      w;
        w = v;
        r = {1'b0, acc} + {1'b0, 64'(w * w)};
        return r[64] ? 64'hFFFF_FFFF_FFFF_FFFF : r[63:0];
    endfunction

    // accumulate one point; on the last point queue the 64 invariants
    function automatic void accumulate_point(point_row_t r);
        int             pan;
        int             tilt;
        longint         rho;
        int             cp;
        int             sp;
        int             ct;
        int             st;
        int             p;
        invariant_exp_t e;
        pan  = int'(r.pan) % 360;
        tilt = int'(r.tilt) % 360;
        rho  = longint'(r.inten) + offset_shadow;
        for (int h1 = 0; h1 < PAN_HARMONICS; h1++)
        begin
            cp = deg_cos(h1 * pan);
            sp = deg_sin(h1 * pan);
            for (int h2 = 0; h2 < TILT_HARMONICS; h2++)
            begin
                ct = deg_cos(h2 * tilt);
                st = deg_sin(h2 * tilt);
                p  = h1 * TILT_HARMONICS + h2;
                add_term(p, 0, rho, cp, ct);
                add_term(p, 1, rho, sp, ct);
                add_term(p, 2, rho, cp, st);
                add_term(p, 3, rho, sp, st);
            end
        end
        if (!r.last)
            return;
        for (int k = 0; k < PAIR_COUNT; k++)
        begin
            e.harm = k[PAIR_W-1:0];
            e.inv  = sq_add(sq_add(64'd0, coef_acc[k][0]), coef_acc[k][2]);
            if (k / TILT_HARMONICS != 0)
                e.inv = sq_add(sq_add(e.inv, coef_acc[k][1]), coef_acc[k][3]);
            e.last = (k == PAIR_COUNT - 1);
            if (r.all_zero)
                e.inv = 64'd0;
            invariant_q = {invariant_q, e};
            for (int f = 0; f < 4; f++)
                coef_acc[k][f] = 0;
        end
    endfunction

    task automatic send_point(point_row_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pan_angle  <= r.pan;
        tilt_angle <= r.tilt;
        intensity  <= r.inten;
        last_point <= r.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_point(r);
        points_sent++;
        if (r.last)
            sets_sent++;
    endtask

    task automatic drain_and_write(logic [15:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (invariant_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        offset_shadow = int'(value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_sets(int n_items);
        point_row_t r;
        int         len;
        int         sent;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++)
            begin
                r.pan      = ANGLE_W'($urandom_range(511));
                r.tilt     = ANGLE_W'($urandom_range(511));
                case ($urandom_range(7))
                    0:       r.inten = 16'hFFFF;
                    1:       r.inten = 16'h0000;
                    default: r.inten = 16'($urandom_range(16'hFFFF));
                endcase
                r.last     = (i == len - 1);
                r.all_zero = 1'b0;
                send_point(r);
                sent++;
            end
        end
    endtask

    // receiver: random stalls, or a long counted hold when requested
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left <= hold_req;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        invariant_exp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (invariant_q.size() == 0)
            begin
                $error("unexpected result harmonic_index=%0d", harmonic_index);
                fail_count++;
            end
            else
            begin
                e = invariant_q.pop_front();
                if (harmonic_index !== e.harm)
                begin
                    $error("harmonic_index exp %0d got %0d", e.harm, harmonic_index);
                    fail_count++;
                end
                if (invariant !== e.inv)
                begin
                    $error("invariant exp %0d got %0d", e.inv, invariant);
                    fail_count++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result exp %0d got %0d", e.last, last_result);
                    fail_count++;
                end
            end
        end
    end

    point_row_t directed_rows[] = '{
        '{9'd0,   9'd0,   16'h0000, 1'b1, 1'b1},
        '{9'd0,   9'd0,   16'h0000, 1'b0, 1'b0},
        '{9'd359, 9'd359, 16'hFFFF, 1'b0, 1'b0},
        '{9'd360, 9'd511, 16'hFFFF, 1'b1, 1'b0},
        '{9'd90,  9'd180, 16'h0001, 1'b1, 1'b0},
        '{9'd270, 9'd45,  16'h8000, 1'b0, 1'b0},
        '{9'd511, 9'd0,   16'hFFFF, 1'b0, 1'b0},
        '{9'd180, 9'd270, 16'h0100, 1'b1, 1'b0},
        '{9'd45,  9'd90,  16'h7FFF, 1'b1, 1'b0},
        '{9'd450, 9'd405, 16'hFFFF, 1'b0, 1'b0},
        '{9'd1,   9'd359, 16'hAAAA, 1'b0, 1'b0},
        '{9'd256, 9'd255, 16'h5555, 1'b1, 1'b0}
    };

    initial
    begin
        for (int k = 0; k <= 90; k++)
            sin_quarter[k] = quarter_sine(k);
        foreach (coef_acc[p, f])
            coef_acc[p][f] = 0;
        offset_shadow = 0;
        fail_count    = 0;
        points_sent   = 0;
        results_seen  = 0;
        sets_sent     = 0;
        hold_req      = 0;
        hold_left     = 0;
        tx_idle_pct   = 9;
        rx_idle_pct   = 53;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pan_angle     = '0;
        tilt_angle    = '0;
        intensity     = '0;
        last_point    = 1'b0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_point(directed_rows[i]);

        drain_and_write(16'hFFFF);
        random_sets(70);

        drain_and_write(16'($urandom_range(16'hFFFF)));
        tx_idle_pct = 53;
        rx_idle_pct = 9;
        random_sets(70);

        drain_and_write(16'h0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the output off long enough to back up the input side
        @(negedge clk);
        hold_req = 3000;
        @(negedge clk);
        hold_req = 0;
        random_sets(60);

        in_valid <= 1'b0;
        while (invariant_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d points in %0d sets, %0d invariants checked,",
                 points_sent, sets_sent, results_seen);
        $display("with rho offsets 0, max and random, stalls on both sides and a long hold.");
        if (fail_count == 0)
            $display("PASS angular_fourier_invariant_engine");
        else
            $display("FAIL angular_fourier_invariant_engine");
        $finish;
    end

endmodule

>>> angular_fourier_invariant_engine.f
rtl/afie_pkg.sv
rtl/afie_trig.sv
rtl/angular_fourier_invariant_engine.sv
tb/tb.sv
